// ===== src/slct_pkg.sv =====
// Shared types and constants for the segmented LRU client table.
// Holds the request and response payloads and the controller/datapath link.
// No dependencies.
package slct_pkg;

	localparam int KEY_W   = 64;
	localparam int TIME_W  = 32;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;

	// Operation codes carried in the func field
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	typedef struct packed {
		logic              func;
		logic [KEY_W-1:0]  key_high;
		logic [KEY_W-1:0]  key_low;
		logic [TIME_W-1:0] time_now;
	} slct_req_t;

	typedef struct packed {
		logic               found;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] entry_count;
	} slct_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture request, start segment reduction
		logic mod_step;  // fold one key byte into the remainder
		logic base;      // latch segment base and fill level
		logic scan_rd;   // read one slot of the segment
		logic commit;    // write back, update state, present response
	} slct_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mod_last;     // last key byte being folded
		logic scan_needed;  // segment has to be walked
		logic scan_last;    // last slot read being issued
		logic out_busy;     // response register still occupied
	} slct_sts_t;

endpackage

// ===== src/segmented_lru_client_table.sv =====
// Segmented LRU client table: lookup and oldest-entry replacement of 128-bit
// client keys. The request channel (req_valid/req_ready/req) takes one
// lookup or insert; the response channel (rsp_valid/rsp_ready/rsp) returns
// one result per request: hit flag, slot and the saturating insert count.
// A request runs alone. Reducing key_high to a segment folds one key byte a
// cycle. The base state then latches the segment base. The segment is
// walked through the single read port of the entry memory, one slot a cycle.
// A drain state then takes in the last read, and then comes the commit.
// The number of slots read is the segment's fill level for a lookup,
// ENTRIES/SEGMENTS for an insert into a full segment, and 0 for an insert
// into a segment with a free slot. With no slot read there is no drain.
// The next request is taken in the cycle after commit.
// The response sits in an output register; if the receiver stalls, the
// block still takes and works a new request and holds at commit until
// the previous response has gone. Reset empties every segment and clears
// the time and count at once; no clearing pass is needed.
// Uses slct_pkg, slct_ctrl and slct_dp.
module segmented_lru_client_table
	import slct_pkg::*;
#(
	parameter int SEGMENTS = 4,
	parameter int ENTRIES  = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  slct_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output slct_rsp_t rsp
);

	slct_cmd_t cmd;
	slct_sts_t sts;

	// Sequencer
	slct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table datapath
	slct_dp #(
		.SEGMENTS (SEGMENTS),
		.ENTRIES  (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== src/slct_ctrl.sv =====
// Sequencer for the segmented LRU client table.
// Steps one request through reduction, scan and commit; uses slct_pkg.
module slct_ctrl
	import slct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  slct_sts_t sts,
	output slct_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_BASE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (sts.mod_last) state_q <= ST_BASE;
				end
				ST_BASE: begin
					state_q <= sts.scan_needed ? ST_SCAN : ST_COMMIT;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && req_valid;
		cmd.mod_step = (state_q == ST_MOD);
		cmd.base     = (state_q == ST_BASE);
		cmd.scan_rd  = (state_q == ST_SCAN);
		cmd.commit   = (state_q == ST_COMMIT) && !sts.out_busy;
	end

	assign req_ready = (state_q == ST_IDLE);

endmodule

// ===== src/slct_dp.sv =====
// Datapath of the segmented LRU client table: entry memory, per-segment
// fill levels, segment reduction, scan compare and response register.
// Uses slct_pkg; driven by slct_ctrl.
module slct_dp
	import slct_pkg::*;
#(
	parameter int SEGMENTS = 4,
	parameter int ENTRIES  = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  slct_req_t req,
	input  slct_cmd_t cmd,
	output slct_sts_t sts,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output slct_rsp_t rsp
);

	localparam int SEG_SIZE = ENTRIES / SEGMENTS;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CNT_W    = (SEG_SIZE > 0) ? $clog2(SEG_SIZE + 1) : 1;
	localparam int UC_W     = $clog2(ENTRIES + 1);
	localparam int SLOT_XW  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int UC_XW    = (UC_W > COUNT_W) ? UC_W : COUNT_W;
	localparam bit HAS_SLOTS = (SEG_SIZE > 0);

	typedef struct packed {
		logic [KEY_W-1:0]  key_high;
		logic [KEY_W-1:0]  key_low;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// Entry memory, one write and one registered read port
	entry_t mem [ENTRIES];

	// Request and working registers
	slct_req_t          req_q;
	logic [SEG_W-1:0]   rem_q;
	logic [2:0]         mod_cnt_q;
	logic [IDX_W-1:0]   base_q;
	logic [CNT_W-1:0]   fill_cur_q;
	logic               seg_full_q;
	logic [CNT_W-1:0]   idx_q;
	entry_t             rd_data_q;
	logic [CNT_W-1:0]   rd_idx_s1;
	logic               rd_vld_s1;
	logic [TIME_W-1:0]  best_stamp_q;
	logic [CNT_W-1:0]   best_idx_q;
	logic               hit_q;
	slct_rsp_t          rsp_q;
	logic               rsp_valid_q;

	// Persistent state
	logic [CNT_W-1:0]   fill_q [SEGMENTS];
	logic [UC_W-1:0]    used_q;
	logic [TIME_W-1:0]  cur_time_q;

	// Remainder of key_high by SEGMENTS, one byte (eight bit steps) a cycle
	logic [7:0]       mod_byte;
	logic [SEG_W-1:0] rem_nxt;

	assign mod_byte = req_q.key_high[{~mod_cnt_q, 3'b000} +: 8];

	always_comb begin
		logic [SEG_W:0]   t;
		logic [SEG_W-1:0] r;
		r = rem_q;
		t = '0;
		for (int k = 7; k >= 0; k--) begin
			t = {r, mod_byte[k]};
			if (t >= (SEG_W+1)'(SEGMENTS)) t = t - (SEG_W+1)'(SEGMENTS);
			r = t[SEG_W-1:0];
		end
		rem_nxt = r;
	end

	// Segment fill level; filled slots always form a prefix of the segment
	logic [CNT_W-1:0] fill_cur;
	logic             seg_full;
	logic             is_ins;

	assign fill_cur = fill_q[rem_q];
	assign seg_full = HAS_SLOTS && (fill_cur == CNT_W'(SEG_SIZE));
	assign is_ins   = (req_q.func == FUNC_INSERT);

	// Scan address and key compare
	logic [IDX_W-1:0] rd_addr;
	logic             key_match;

	assign rd_addr   = base_q + IDX_W'(idx_q);
	assign key_match = (rd_data_q.key_high == req_q.key_high) &&
	                   (rd_data_q.key_low == req_q.key_low);

	// Commit: victim or hit slot, new stamp, counters
	logic [CNT_W-1:0]   wr_off;
	logic [IDX_W-1:0]   wr_addr;
	logic [TIME_W-1:0]  wr_time;
	logic               wr_en;
	logic               found;
	logic [UC_W-1:0]    used_nxt;
	logic [SLOT_XW-1:0] slot_x;
	logic [UC_XW-1:0]   used_x;

	assign wr_off  = (is_ins && !seg_full_q) ? fill_cur_q : best_idx_q;
	assign wr_addr = base_q + IDX_W'(wr_off);
	assign wr_time = (is_ins || (req_q.time_now == '0)) ?
	                 (is_ins ? req_q.time_now : cur_time_q) : req_q.time_now;
	assign found   = is_ins ? HAS_SLOTS : hit_q;
	assign wr_en   = cmd.commit && HAS_SLOTS && (is_ins || hit_q);
	assign used_nxt = (is_ins && HAS_SLOTS && (used_q != UC_W'(ENTRIES))) ?
	                  used_q + 1'b1 : used_q;
	assign slot_x  = SLOT_XW'(wr_addr);
	assign used_x  = UC_XW'(used_nxt);

	// Memory port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{key_high: req_q.key_high, key_low: req_q.key_low,
			                  stamp: wr_time};
		end
		if (cmd.scan_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req;
			rem_q     <= '0;
			mod_cnt_q <= '0;
		end
		if (cmd.mod_step) begin
			rem_q     <= rem_nxt;
			mod_cnt_q <= mod_cnt_q + 3'd1;
		end
		if (cmd.base) begin
			base_q     <= IDX_W'(rem_q * SEG_SIZE);
			fill_cur_q <= fill_cur;
			seg_full_q <= seg_full;
			idx_q      <= '0;
		end
		if (cmd.scan_rd) begin
			rd_idx_s1 <= idx_q;
			idx_q     <= idx_q + 1'b1;
		end
		// Lowest matching slot for lookup, oldest stamp (lowest on tie) for insert
		if (rd_vld_s1) begin
			if (is_ins) begin
				if ((rd_idx_s1 == '0) || (rd_data_q.stamp < best_stamp_q)) begin
					best_stamp_q <= rd_data_q.stamp;
					best_idx_q   <= rd_idx_s1;
				end
			end else if (!hit_q && key_match) begin
				best_idx_q <= rd_idx_s1;
			end
		end
		if (cmd.commit) begin
			rsp_q.found       <= found;
			rsp_q.slot        <= found ? slot_x[SLOT_W-1:0] : '0;
			rsp_q.entry_count <= used_x[COUNT_W-1:0];
		end
	end

	// Control and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			used_q      <= '0;
			cur_time_q  <= '0;
			for (int s = 0; s < SEGMENTS; s++) fill_q[s] <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.base) begin
				hit_q <= 1'b0;
			end else if (rd_vld_s1 && !is_ins && key_match) begin
				hit_q <= 1'b1;
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				if (is_ins || hit_q) cur_time_q <= wr_time;
				used_q <= used_nxt;
				if (is_ins && HAS_SLOTS && !seg_full_q) begin
					fill_q[rem_q] <= fill_q[rem_q] + 1'b1;
				end
			end
		end
	end

	// Status to controller
	always_comb begin
		sts             = '0;
		sts.mod_last    = (mod_cnt_q == 3'd7);
		sts.scan_needed = HAS_SLOTS && (is_ins ? seg_full : (fill_cur != '0));
		sts.scan_last   = (idx_q == fill_cur_q - 1'b1);
		sts.out_busy    = rsp_valid_q && !rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/slct_checker.sv =====
// Port-level checks for the segmented LRU client table, bound to the top.
// Uses slct_pkg.
module slct_checker
	import slct_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input slct_rsp_t rsp
);

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// One request at a time: busy right after a request is taken
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while busy");

	// A response never appears the cycle after a request is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response too early");

	// A miss reports slot zero
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.slot == '0)
		else $error("miss with nonzero slot");

endmodule

bind segmented_lru_client_table slct_checker u_slct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== tb/sv/testbench.sv =====
// Testbench for segmented_lru_client_table: directed and random lookup/insert
// traffic, checked against a table predictor held here. Depends on slct_pkg
// and the segmented_lru_client_table RTL.
module testbench;
	import slct_pkg::*;

	localparam int SEGMENTS     = 4;
	localparam int ENTRIES      = 64;
	localparam int SEG_SLOTS    = ENTRIES / SEGMENTS;
	localparam int KEY_POOL     = 24;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	slct_req_t req       = '0;
	logic      rsp_ready = 1'b0;
	logic      req_ready;
	logic      rsp_valid;
	slct_rsp_t rsp;

	// Predicted table contents
	logic [KEY_W-1:0]  tbl_key_high [ENTRIES] = '{default: '0};
	logic [KEY_W-1:0]  tbl_key_low  [ENTRIES] = '{default: '0};
	logic [TIME_W-1:0] tbl_stamp    [ENTRIES] = '{default: '0};
	bit                tbl_used     [ENTRIES] = '{default: 1'b0};
	logic [TIME_W-1:0] tbl_now  = '0;
	int                tbl_fill = 0;

	// Keys reused by the random traffic so that lookups hit and segments fill
	logic [KEY_W-1:0] pool_high [KEY_POOL];
	logic [KEY_W-1:0] pool_low  [KEY_POOL];

	slct_rsp_t expected_rsp[$];
	int        send_idle_pct  = 0;
	int        rsp_stall_pct  = 0;
	int        mismatch_count = 0;
	int        cycle_count    = 0;

	segmented_lru_client_table #(
		.SEGMENTS(SEGMENTS),
		.ENTRIES (ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #10 clk = ~clk;

	// Table predictor: applies one request, returns the response it should give
	function automatic slct_rsp_t predict_client_table(input slct_req_t r);
		slct_rsp_t res;
		int        base;
		int        victim;
		bit        have_free;
		res       = '0;
		base      = int'(r.key_high % SEGMENTS) * SEG_SLOTS;
		victim    = base;
		have_free = 1'b0;
		if (r.func == FUNC_LOOKUP) begin
			// lowest valid slot with an exact key match
			for (int i = 0; i < SEG_SLOTS; i++) begin
				if (!res.found && tbl_used[base+i] && tbl_key_high[base+i] == r.key_high
						&& tbl_key_low[base+i] == r.key_low) begin
					res.found = 1'b1;
					victim    = base + i;
				end
			end
			if (res.found) begin
				if (r.time_now != '0)
					tbl_now = r.time_now;
				tbl_stamp[victim] = tbl_now;
				res.slot = SLOT_W'(victim);
			end
		end else begin
			tbl_now = r.time_now;
			// free slot first, else oldest stamp, ties to the lowest slot
			for (int i = 0; i < SEG_SLOTS; i++) begin
				if (!have_free && !tbl_used[base+i]) begin
					victim    = base + i;
					have_free = 1'b1;
				end
			end
			if (!have_free) begin
				for (int i = 1; i < SEG_SLOTS; i++)
					if (tbl_stamp[base+i] < tbl_stamp[victim])
						victim = base + i;
			end
			tbl_key_high[victim] = r.key_high;
			tbl_key_low[victim]  = r.key_low;
			tbl_stamp[victim]    = r.time_now;
			tbl_used[victim]     = 1'b1;
			if (tbl_fill < ENTRIES)
				tbl_fill++;
			res.found = 1'b1;
			res.slot  = SLOT_W'(victim);
		end
		res.entry_count = COUNT_W'(tbl_fill);
		return res;
	endfunction

	// Send one request, with a random idle gap first; predict it on acceptance
	task automatic send_request(input logic func, input logic [KEY_W-1:0] khi,
			input logic [KEY_W-1:0] klo, input logic [TIME_W-1:0] t);
		slct_req_t r;
		r.func     = func;
		r.key_high = khi;
		r.key_low  = klo;
		r.time_now = t;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		expected_rsp.push_back(predict_client_table(r));
	endtask

	// Lookups into an empty table, zero key included, must miss
	task automatic test_empty_table();
		send_request(FUNC_LOOKUP, '0, '0, 32'd7);
		send_request(FUNC_LOOKUP, '1, '1, '1);
	endtask

	// Insert, hit with zero and maximum time, miss on a partial key match
	task automatic test_insert_lookup();
		send_request(FUNC_INSERT, '0, '0, 32'd100);
		send_request(FUNC_LOOKUP, '0, '0, '0);
		send_request(FUNC_LOOKUP, '0, '0, '1);
		send_request(FUNC_LOOKUP, '0, 64'd1, 32'd5);
		send_request(FUNC_LOOKUP, '0, '0, '0);
	endtask

	// The same key twice: lookup reports the lower slot
	task automatic test_duplicate_keys();
		send_request(FUNC_INSERT, 64'd1, 64'h5555_5555_5555_5555, 32'd20);
		send_request(FUNC_INSERT, 64'd1, 64'h5555_5555_5555_5555, 32'd21);
		send_request(FUNC_LOOKUP, 64'd1, 64'h5555_5555_5555_5555, 32'd22);
	endtask

	// All-ones and mixed keys in the top segment, and an alternating-bit lookup in segment 2
	task automatic test_field_extremes();
		send_request(FUNC_INSERT, '1, '1, '1);
		send_request(FUNC_INSERT, '1, '0, '0);
		send_request(FUNC_LOOKUP, '1, '1, '0);
		send_request(FUNC_LOOKUP, '1, '0, 32'd3);
		send_request(FUNC_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 32'd9);
	endtask

	// Mixed traffic over a key pool: hits, misses, near misses, evictions
	task automatic test_random_traffic(input int count);
		logic [KEY_W-1:0]  khi;
		logic [KEY_W-1:0]  klo;
		logic [TIME_W-1:0] t;
		logic              func;
		int                pick;
		int                k;
		for (int n = 0; n < count; n++) begin
			k    = $urandom_range(KEY_POOL - 1);
			khi  = pool_high[k];
			klo  = pool_low[k];
			func = FUNC_LOOKUP;
			pick = $urandom_range(99);
			if (pick < 40) begin
				func = FUNC_INSERT;
			end else if (pick < 48) begin
				func = FUNC_INSERT;
				khi  = {$urandom, $urandom};
				klo  = {$urandom, $urandom};
			end else if (pick < 56) begin
				khi = {$urandom, $urandom};
				klo = {$urandom, $urandom};
			end else if (pick < 62) begin
				klo[$urandom_range(KEY_W - 1)] ^= 1'b1;
			end
			// small steps give stamp ties; zero, wild and maximum times now and then
			pick = $urandom_range(99);
			if (pick < 12)
				t = '0;
			else if (pick < 18)
				t = $urandom;
			else if (pick < 20)
				t = '1;
			else
				t = tbl_now + TIME_W'($urandom_range(3));
			send_request(func, khi, klo, t);
		end
	endtask

	// Receiver side stalls
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

	// Compare each response with the oldest prediction
	always @(posedge clk) begin : rsp_check
		slct_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("response with no request outstanding: found=%0b slot=%0d count=%0d",
						rsp.found, rsp.slot, rsp.entry_count);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.found !== want.found || rsp.slot !== want.slot
						|| rsp.entry_count !== want.entry_count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected found=%0b slot=%0d count=%0d, got found=%0b slot=%0d count=%0d",
							want.found, want.slot, want.entry_count,
							rsp.found, rsp.slot, rsp.entry_count);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("segmented_lru_client_table verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_high[i] = {$urandom, $urandom};
			pool_low[i]  = {$urandom, $urandom};
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 27;
		rsp_stall_pct = 47;
		test_empty_table();
		test_insert_lookup();
		test_duplicate_keys();
		test_field_extremes();
		test_random_traffic(320);

		send_idle_pct = 47;
		rsp_stall_pct = 27;
		test_random_traffic(320);

		send_idle_pct = 0;
		rsp_stall_pct = 0;
		test_random_traffic(320);

		// drain outstanding responses, then watch for strays
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp.size() == 0)
			$display("segmented_lru_client_table verification clean");
		else
			$display("segmented_lru_client_table verification failed");
		$finish;
	end

endmodule
